>>> sv/swqt_pkg.sv
// shared types and constants for the semaphore wait queue table
package swqt_pkg;
    localparam int KeyWidth  = 32;
    localparam int ProcWidth = 5;
    localparam int NumProc   = 32;

    typedef enum logic [1:0] {
        CMD_BLOCK   = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_DEQUEUE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic search_step;
        logic search_init;
        logic exec;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic search_done;
    } t_stat;
endpackage

>>> sv/swqt_ctrl.sv
// controller state machine for the semaphore wait queue table
module swqt_ctrl import swqt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.load        = 1'b1;
                    o_ctrl.search_init = 1'b1;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_ctrl.search_step = 1'b1;
                if (i_stat.search_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_no_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while result pending");
endmodule

>>> sv/swqt_dp.sv
// datapath for the semaphore wait queue table: descriptor pool, queues, search
module swqt_dp import swqt_pkg::*; #(
    parameter int POOL_SIZE = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    output t_stat                o_stat,
    input  logic [1:0]           i_cmd,
    input  logic [KeyWidth-1:0]  i_sem_key,
    input  logic [ProcWidth-1:0] i_proc_id,
    output logic [1:0]           o_status,
    output logic                 o_proc_found,
    output logic [ProcWidth-1:0] o_proc_out
);
    localparam int DW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    logic [POOL_SIZE-1:0]   r_used;
    logic [KeyWidth-1:0]    r_dkey  [POOL_SIZE];
    logic [ProcWidth-1:0]   r_dhead [POOL_SIZE];
    logic [ProcWidth-1:0]   r_dtail [POOL_SIZE];
    logic [NumProc-1:0]     r_wait;
    logic [KeyWidth-1:0]    r_wkey  [NumProc];
    logic [ProcWidth-1:0]   r_next  [NumProc];
    logic [ProcWidth-1:0]   r_prev  [NumProc];

    logic [1:0]           r_cmd;
    logic [KeyWidth-1:0]  r_key;
    logic [ProcWidth-1:0] r_pid;
    logic [DW-1:0]        r_idx;
    logic                 r_hit, r_free_ok;
    logic [DW-1:0]        r_hit_d, r_free_d;

    logic [DW-1:0] w_idx;
    logic [KeyWidth-1:0] w_search_key;
    assign w_idx = r_idx;
    assign o_stat.search_done = (r_idx == DW'(POOL_SIZE - 1));

    // key for the search: remove looks up the key the process waits on
    always_comb begin
        w_search_key = (r_cmd == CMD_REMOVE) ? r_wkey[r_pid] : r_key;
    end

    // one descriptor compared per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_cmd;
            r_key <= i_sem_key;
            r_pid <= i_proc_id;
        end
        if (i_ctrl.search_init) begin
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_hit_d   <= '0;
            r_free_d  <= '0;
        end else if (i_ctrl.search_step) begin
            if (!o_stat.search_done) r_idx <= r_idx + DW'(1);
            if (!r_hit && r_used[w_idx] && r_dkey[w_idx] == w_search_key) begin
                r_hit   <= 1'b1;
                r_hit_d <= w_idx;
            end
            if (!r_free_ok && !r_used[w_idx]) begin
                r_free_ok <= 1'b1;
                r_free_d  <= w_idx;
            end
        end
    end

    // process to unlink and its queue neighbours for the update step
    logic [ProcWidth-1:0] w_up;
    logic [ProcWidth-1:0] w_prv, w_nxt;
    logic                 w_unlink;
    always_comb begin
        w_unlink = 1'b0;
        w_up     = r_pid;
        if (r_cmd == CMD_REMOVE) begin
            w_unlink = r_wait[r_pid] && r_hit;
            w_up     = r_pid;
        end else if (r_cmd == CMD_DEQUEUE) begin
            w_unlink = r_hit;
            w_up     = r_dhead[r_hit_d];
        end
        w_prv = r_prev[w_up];
        w_nxt = r_next[w_up];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_wait <= '0;
        end else if (i_ctrl.exec) begin
            if (r_cmd == CMD_BLOCK && !r_wait[r_pid]) begin
                if (r_hit) begin
                    r_next[r_dtail[r_hit_d]] <= r_pid;
                    r_prev[r_pid]            <= r_dtail[r_hit_d];
                    r_dtail[r_hit_d]         <= r_pid;
                    r_wait[r_pid]            <= 1'b1;
                    r_wkey[r_pid]            <= r_key;
                end else if (r_free_ok) begin
                    r_used[r_free_d]  <= 1'b1;
                    r_dkey[r_free_d]  <= r_key;
                    r_dhead[r_free_d] <= r_pid;
                    r_dtail[r_free_d] <= r_pid;
                    r_wait[r_pid]     <= 1'b1;
                    r_wkey[r_pid]     <= r_key;
                end
            end
            if (w_unlink) begin
                if (r_dhead[r_hit_d] == w_up && r_dtail[r_hit_d] == w_up) begin
                    r_used[r_hit_d] <= 1'b0;
                end else if (r_dhead[r_hit_d] == w_up) begin
                    r_dhead[r_hit_d] <= w_nxt;
                end else if (r_dtail[r_hit_d] == w_up) begin
                    r_dtail[r_hit_d] <= w_prv;
                end else begin
                    r_next[w_prv] <= w_nxt;
                    r_prev[w_nxt] <= w_prv;
                end
                r_wait[w_up] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            o_status     <= ST_NOT_FOUND;
            o_proc_found <= 1'b0;
            o_proc_out   <= '0;
            unique case (t_cmd'(r_cmd))
                CMD_BLOCK: begin
                    if (!r_wait[r_pid]) begin
                        o_status <= (r_hit || r_free_ok) ? ST_DONE : ST_FULL;
                    end
                end
                CMD_PEEK: begin
                    if (r_hit) begin
                        o_status     <= ST_DONE;
                        o_proc_found <= 1'b1;
                        o_proc_out   <= r_dhead[r_hit_d];
                    end
                end
                CMD_REMOVE, CMD_DEQUEUE: begin
                    if (w_unlink) begin
                        o_status     <= ST_DONE;
                        o_proc_found <= 1'b1;
                        o_proc_out   <= w_up;
                    end
                end
                default: ;
            endcase
        end
    end

    a_hit_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.exec && r_hit) |-> r_used[r_hit_d]) else $error("hit on free descriptor");
endmodule

>>> sv/semaphore_wait_queue_table.sv
// top level of the semaphore wait queue table
//  channel | direction | handshake          | fields
//  in      | input     | i_valid / o_ready  | i_cmd, i_sem_key, i_proc_id
//  out     | output    | o_valid / i_ready  | o_status, o_proc_found, o_proc_out
// an item passes through a load step, a search that compares the descriptors
// one at a time over all POOL_SIZE entries, and an update step;
// then the result is shown until taken; a stalled output holds the block
// synchronous reset frees every descriptor and clears all waiting flags at once
module semaphore_wait_queue_table import swqt_pkg::*; #(
    parameter int POOL_SIZE = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [KeyWidth-1:0]  i_sem_key,
    input  logic [ProcWidth-1:0] i_proc_id,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic                 o_proc_found,
    output logic [ProcWidth-1:0] o_proc_out
);
    t_ctrl w_ctrl;
    t_stat w_stat;

    // sequencing of load, search, update and result
    swqt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // descriptor pool and linked queues
    swqt_dp #(.POOL_SIZE(POOL_SIZE)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_stat       (w_stat),
        .i_cmd        (i_cmd),
        .i_sem_key    (i_sem_key),
        .i_proc_id    (i_proc_id),
        .o_status     (o_status),
        .o_proc_found (o_proc_found),
        .o_proc_out   (o_proc_out)
    );

    // proc_found only with status done
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_proc_found) |-> (o_status == ST_DONE))
        else $error("found without done");
endmodule

>>> tb/tb_top.sv
// self-checking testbench for the semaphore wait queue table
`timescale 1ns / 100ps

module tb_top;
    import swqt_pkg::*;

    localparam int PoolSize  = 32;
    localparam int IdleLimit = 20000;   // cycles with no item accepted and no result taken before giving up

    // one command item as driven on the input channel
    typedef struct packed {
        t_cmd                 cmd;
        logic [KeyWidth-1:0]  key;
        logic [ProcWidth-1:0] pid;
    } t_op;

    // one result item as seen on the output channel
    typedef struct packed {
        t_status              status;
        logic                 found;
        logic [ProcWidth-1:0] pout;
    } t_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_cmd = '0;
    logic [KeyWidth-1:0]  i_sem_key = '0;
    logic [ProcWidth-1:0] i_proc_id = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_status;
    logic                 o_proc_found;
    logic [ProcWidth-1:0] o_proc_out;

    semaphore_wait_queue_table #(.POOL_SIZE(PoolSize)) dut (.*);

    always #10 i_clk = ~i_clk;

    // shadow of the wait queues: per key an ordered list of waiting processes
    logic [KeyWidth-1:0]  q_key  [PoolSize];
    logic                 q_used [PoolSize];
    logic [ProcWidth-1:0] q_list [PoolSize][$];
    logic                 waiting [NumProc];
    logic [KeyWidth-1:0]  wait_key [NumProc];

    t_op  pending_ops[$];
    t_res expected_res[$];
    int   errors = 0;
    int   in_gap = 0, out_gap = 0, idle_cycles = 0;

    // key pool kept small so that keys collide and the table fills up
    logic [KeyWidth-1:0] key_set[40];

    function automatic int find_slot(logic [KeyWidth-1:0] k);
        for (int d = 0; d < PoolSize; d++)
            if (q_used[d] && q_key[d] == k) return d;
        return -1;
    endfunction

    // apply one command to the shadow table and return the expected result
    function automatic t_res apply_op(t_op op);
        t_res r;
        int   d;
        r = '{ST_NOT_FOUND, 1'b0, '0};
        case (op.cmd)
            CMD_BLOCK: begin
                if (!waiting[op.pid]) begin
                    d = find_slot(op.key);
                    if (d < 0) begin
                        for (int i = 0; i < PoolSize; i++)
                            if (!q_used[i] && d < 0) d = i;
                        if (d < 0) r.status = ST_FULL;
                        else begin
                            q_used[d] = 1'b1;
                            q_key[d] = op.key;
                            q_list[d].delete();
                        end
                    end
                    if (d >= 0) begin
                        q_list[d].push_back(op.pid);
                        waiting[op.pid] = 1'b1;
                        wait_key[op.pid] = op.key;
                        r.status = ST_DONE;
                    end
                end
            end
            CMD_PEEK: begin
                d = find_slot(op.key);
                if (d >= 0) r = '{ST_DONE, 1'b1, q_list[d][0]};
            end
            CMD_REMOVE: begin
                if (waiting[op.pid]) begin
                    d = find_slot(wait_key[op.pid]);
                    if (d >= 0) begin
                        for (int i = 0; i < q_list[d].size(); i++)
                            if (q_list[d][i] == op.pid) begin
                                q_list[d].delete(i);
                                break;
                            end
                        if (q_list[d].size() == 0) q_used[d] = 1'b0;
                        waiting[op.pid] = 1'b0;
                        r = '{ST_DONE, 1'b1, op.pid};
                    end
                end
            end
            default: begin
                d = find_slot(op.key);
                if (d >= 0) begin
                    r = '{ST_DONE, 1'b1, q_list[d][0]};
                    void'(q_list[d].pop_front());
                    if (q_list[d].size() == 0) q_used[d] = 1'b0;
                    waiting[r.pout] = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

    // mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_op rand_op();
        t_op op;
        int  r;
        r = $urandom_range(0, 99);
        op.cmd = r < 45 ? CMD_BLOCK : r < 60 ? CMD_PEEK : r < 78 ? CMD_REMOVE : CMD_DEQUEUE;
        op.key = ($urandom_range(0, 9) == 0) ? $urandom() : key_set[$urandom_range(0, 39)];
        op.pid = $urandom_range(0, NumProc - 1);
        return op;
    endfunction

    // driver: present the next pending item, hold it until accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                void'(pending_ops.pop_front());
                in_gap <= pick_gap();
            end
            if (i_valid && !o_ready) begin
                // hold the item unchanged
            end else if (in_gap > 0 && !(i_valid && o_ready)) begin
                in_gap <= in_gap - 1;
                i_valid <= 1'b0;
            end else if (!(i_valid && o_ready) && pending_ops.size() > 0) begin
                i_valid   <= 1'b1;
                i_cmd     <= pending_ops[0].cmd;
                i_sem_key <= pending_ops[0].key;
                i_proc_id <= pending_ops[0].pid;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // predict on acceptance so the order matches the block
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            expected_res.push_back(apply_op('{t_cmd'(i_cmd), i_sem_key, i_proc_id}));
    end

    // monitor: random output stalls, compare each accepted result
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_res.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    exp_r = expected_res.pop_front();
                    if (o_status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, o_status);
                        errors++;
                    end
                    if (o_proc_found !== exp_r.found) begin
                        $error("proc_found exp %0d got %0d", exp_r.found, o_proc_found);
                        errors++;
                    end
                    if (o_proc_out !== exp_r.pout) begin
                        $error("proc_out exp %0d got %0d", exp_r.pout, o_proc_out);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_ready <= 1'b0;
            end else if (i_ready && $urandom_range(0, 3) == 0) begin
                out_gap <= pick_gap();
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
            // watchdog on inactivity
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IdleLimit) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        t_op op;
        for (int i = 0; i < PoolSize; i++) q_used[i] = 1'b0;
        for (int i = 0; i < NumProc; i++) waiting[i] = 1'b0;
        for (int i = 0; i < 40; i++) key_set[i] = $urandom();
        key_set[0] = '0;
        key_set[1] = '1;

        // directed: misses on an empty table, field extremes
        pending_ops.push_back('{CMD_PEEK, 32'h0, 5'd0});
        pending_ops.push_back('{CMD_DEQUEUE, 32'hFFFF_FFFF, 5'd0});
        pending_ops.push_back('{CMD_REMOVE, 32'h0, 5'd31});
        pending_ops.push_back('{CMD_BLOCK, 32'hFFFF_FFFF, 5'd31});
        pending_ops.push_back('{CMD_BLOCK, 32'hFFFF_FFFF, 5'd0});
        pending_ops.push_back('{CMD_BLOCK, 32'hFFFF_FFFF, 5'd7});
        // already waiting
        pending_ops.push_back('{CMD_BLOCK, 32'h0, 5'd31});
        pending_ops.push_back('{CMD_PEEK, 32'hFFFF_FFFF, 5'd3});
        // remove from the middle, then head, then dequeue the last
        pending_ops.push_back('{CMD_REMOVE, 32'h0, 5'd0});
        pending_ops.push_back('{CMD_REMOVE, 32'h0, 5'd31});
        pending_ops.push_back('{CMD_DEQUEUE, 32'hFFFF_FFFF, 5'd0});
        pending_ops.push_back('{CMD_PEEK, 32'hFFFF_FFFF, 5'd0});
        // fill the pool with distinct keys, then block a process that already waits
        for (int i = 0; i < PoolSize; i++)
            pending_ops.push_back('{CMD_BLOCK, 32'h8000_0000 + i, 5'(i)});
        pending_ops.push_back('{CMD_BLOCK, 32'h1234_5678, 5'd0});
        pending_ops.push_back('{CMD_DEQUEUE, 32'h8000_001F, 5'd0});
        pending_ops.push_back('{CMD_BLOCK, 32'h5555_AAAA, 5'd31});
        // drain the table by removing every process
        for (int i = 0; i < NumProc; i++)
            pending_ops.push_back('{CMD_REMOVE, 32'h0, 5'(i)});

        // random, mostly colliding keys
        for (int i = 0; i < 1170; i++) begin
            op = rand_op();
            pending_ops.push_back(op);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && !i_valid);
        wait (expected_res.size() == 0);
        repeat (4 * PoolSize) @(posedge i_clk);
        if (errors == 0 && expected_res.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

>>> files.f
sv/swqt_pkg.sv
sv/swqt_ctrl.sv
sv/swqt_dp.sv
sv/semaphore_wait_queue_table.sv
tb/tb_top.sv
